/* design/bmp_pkg.sv */
// shared types, command codes and arithmetic helpers for the bone matrix palette unit
`timescale 1ns / 1ps
package bmp_pkg;

   localparam int DEFAULT_MAX_BONES = 64;

   typedef logic [5:0]         bone_idx_type;
   typedef logic signed [6:0]  parent_type;
   typedef logic [1:0]         row_type;
   typedef logic signed [31:0] q16_type;
   typedef logic [63:0]        quat_type;
   typedef logic [47:0]        scale_type;
   typedef logic [127:0]       mat_row_type;

   localparam q16_type ONE_Q16 = 32'sd65536;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_POSE = 1'b1;

   // datapath operations
   localparam logic [4:0] OP_NOP  = 5'd0;
   localparam logic [4:0] OP_TAKE = 5'd1;
   localparam logic [4:0] OP_CLR  = 5'd2;
   localparam logic [4:0] OP_QMUL = 5'd3;
   localparam logic [4:0] OP_QACC = 5'd4;
   localparam logic [4:0] OP_SMUL = 5'd5;
   localparam logic [4:0] OP_SACC = 5'd6;
   localparam logic [4:0] OP_ROOT = 5'd7;
   localparam logic [4:0] OP_PRD  = 5'd8;
   localparam logic [4:0] OP_GMUL = 5'd9;
   localparam logic [4:0] OP_GACC = 5'd10;
   localparam logic [4:0] OP_WR   = 5'd11;
   localparam logic [4:0] OP_ORD  = 5'd12;
   localparam logic [4:0] OP_OLD  = 5'd13;
   localparam logic [4:0] OP_FMUL = 5'd14;
   localparam logic [4:0] OP_FACC = 5'd15;
   localparam logic [4:0] OP_EMIT = 5'd16;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] i;
      logic [1:0] j;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic req_pose;
      logic is_root;
      logic out_free;
   } status_type;

   function automatic q16_type sat32(input logic signed [67:0] x);
      logic same;
      same = (&x[67:31]) | ~(|x[67:31]);
      if (same) begin
         return x[31:0];
      end else if (x[67]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7fff_ffff;
      end
   endfunction

   function automatic logic signed [67:0] sext68(input logic signed [63:0] v);
      return {{4{v[63]}}, v};
   endfunction

endpackage

/* design/bmp_if.sv */
// request and response channel interfaces
`timescale 1ns / 1ps
interface bmp_req_if;
   import bmp_pkg::*;
   logic         valid;
   logic         ready;
   logic         command;
   bone_idx_type bone_index;
   parent_type   parent_index;
   row_type      row_index;
   q16_type      val0;
   q16_type      val1;
   q16_type      val2;
   q16_type      val3;
   quat_type     quat_packed;
   scale_type    scale_packed;

   modport source(output valid, command, bone_index, parent_index, row_index,
                  val0, val1, val2, val3, quat_packed, scale_packed,
                  input ready);
   modport sink(input valid, command, bone_index, parent_index, row_index,
                val0, val1, val2, val3, quat_packed, scale_packed,
                output ready);
endinterface

interface bmp_rsp_if;
   import bmp_pkg::*;
   logic         valid;
   logic         ready;
   bone_idx_type out_bone;
   row_type      out_row;
   q16_type      col0;
   q16_type      col1;
   q16_type      col2;
   q16_type      col3;
   logic         last_row;

   modport source(output valid, out_bone, out_row, col0, col1, col2, col3, last_row,
                  input ready);
   modport sink(input valid, out_bone, out_row, col0, col1, col2, col3, last_row,
                output ready);
endinterface

/* design/bmp_datapath.sv */
// datapath: four-lane multiplier, matrix registers, global and offset memories
`timescale 1ns / 1ps
module bmp_datapath #(
   parameter int MAX_BONES = bmp_pkg::DEFAULT_MAX_BONES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bmp_pkg::cmd_type      cmd,
   output bmp_pkg::status_type   status,
   input  logic                  req_command,
   input  bmp_pkg::bone_idx_type req_bone_index,
   input  bmp_pkg::parent_type   req_parent_index,
   input  bmp_pkg::row_type      req_row_index,
   input  bmp_pkg::q16_type      req_val0,
   input  bmp_pkg::q16_type      req_val1,
   input  bmp_pkg::q16_type      req_val2,
   input  bmp_pkg::q16_type      req_val3,
   input  bmp_pkg::quat_type     req_quat_packed,
   input  bmp_pkg::scale_type    req_scale_packed,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bmp_pkg::bone_idx_type rsp_out_bone,
   output bmp_pkg::row_type      rsp_out_row,
   output bmp_pkg::q16_type      rsp_col0,
   output bmp_pkg::q16_type      rsp_col1,
   output bmp_pkg::q16_type      rsp_col2,
   output bmp_pkg::q16_type      rsp_col3,
   output logic                  rsp_last_row
);
   import bmp_pkg::*;

   localparam int OFF_DEPTH = MAX_BONES * 4;
   localparam int GLB_DEPTH = MAX_BONES * 3;
   localparam int OFF_AW    = $clog2(OFF_DEPTH);
   localparam int GLB_AW    = $clog2(GLB_DEPTH);
   localparam logic signed [35:0] ROT_ONE = 36'sd268435456;

   // latched item
   bone_idx_type bone_ff;
   parent_type   parent_ff;
   q16_type      tr_ff [3];
   quat_type     quat_ff;
   scale_type    scale_ff;

   logic signed [31:0] qp_ff  [9];   // xx yy zz xy xz yz wx wy wz
   logic signed [63:0] mul_ff [4];
   q16_type            loc_ff [3][4];
   q16_type            g_ff   [3][4];
   q16_type            off_ff [4][4];
   q16_type            fin_ff [4];
   mat_row_type        prow_ff;
   mat_row_type        ord_ff;
   logic [OFF_AW-1:0]  clr_ff;

   logic               rsp_valid_ff;
   bone_idx_type       rsp_bone_ff;
   row_type            rsp_row_ff;
   q16_type            rsp_col_ff [4];
   logic               rsp_last_ff;

   mat_row_type glb_mem [GLB_DEPTH];
   mat_row_type off_mem [OFF_DEPTH];

   logic signed [31:0] mul_a [4];
   logic signed [31:0] mul_b [4];
   logic signed [23:0] rot   [3][3];
   logic signed [67:0] acc_sum;
   logic signed [15:0] qx, qy, qz, qw;
   logic               req_bone_ok;
   logic [9:0]         take_off_addr;
   logic [9:0]         rd_off_addr;
   logic [9:0]         par_glb_addr;
   logic [9:0]         wr_glb_addr;
   mat_row_type        clr_row;
   mat_row_type        load_row;

   function automatic logic signed [35:0] ext36(input logic signed [31:0] v);
      return {{4{v[31]}}, v};
   endfunction

   function automatic logic signed [23:0] rnd12(input logic signed [35:0] e);
      logic signed [35:0] t;
      t = e + 36'sd2048;
      return t[35:12];
   endfunction

   assign qx = quat_ff[15:0];
   assign qy = quat_ff[31:16];
   assign qz = quat_ff[47:32];
   assign qw = quat_ff[63:48];

   always_comb begin
      rot[0][0] = rnd12(ROT_ONE - ((ext36(qp_ff[1]) + ext36(qp_ff[2])) <<< 1));
      rot[0][1] = rnd12((ext36(qp_ff[3]) - ext36(qp_ff[8])) <<< 1);
      rot[0][2] = rnd12((ext36(qp_ff[4]) + ext36(qp_ff[7])) <<< 1);
      rot[1][0] = rnd12((ext36(qp_ff[3]) + ext36(qp_ff[8])) <<< 1);
      rot[1][1] = rnd12(ROT_ONE - ((ext36(qp_ff[0]) + ext36(qp_ff[2])) <<< 1));
      rot[1][2] = rnd12((ext36(qp_ff[5]) - ext36(qp_ff[6])) <<< 1);
      rot[2][0] = rnd12((ext36(qp_ff[4]) - ext36(qp_ff[7])) <<< 1);
      rot[2][1] = rnd12((ext36(qp_ff[5]) + ext36(qp_ff[6])) <<< 1);
      rot[2][2] = rnd12(ROT_ONE - ((ext36(qp_ff[0]) + ext36(qp_ff[1])) <<< 1));
   end

   // operand selection for the four multiplier lanes
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         mul_a[k] = '0;
         mul_b[k] = '0;
      end
      case (cmd.op)
         OP_QMUL: begin
            case (cmd.j)
               2'd0: begin
                  mul_a[0] = 32'(qx); mul_b[0] = 32'(qx);
                  mul_a[1] = 32'(qy); mul_b[1] = 32'(qy);
                  mul_a[2] = 32'(qz); mul_b[2] = 32'(qz);
                  mul_a[3] = 32'(qx); mul_b[3] = 32'(qy);
               end
               2'd1: begin
                  mul_a[0] = 32'(qx); mul_b[0] = 32'(qz);
                  mul_a[1] = 32'(qy); mul_b[1] = 32'(qz);
                  mul_a[2] = 32'(qw); mul_b[2] = 32'(qx);
                  mul_a[3] = 32'(qw); mul_b[3] = 32'(qy);
               end
               default: begin
                  mul_a[0] = 32'(qw); mul_b[0] = 32'(qz);
               end
            endcase
         end
         OP_SMUL: begin
            for (int k = 0; k < 3; k++) begin
               mul_a[k] = 32'(rot[cmd.i][k]);
               mul_b[k] = {16'b0, scale_ff[16*k +: 16]};
            end
         end
         OP_GMUL: begin
            for (int k = 0; k < 3; k++) begin
               mul_a[k] = prow_ff[32*k +: 32];
               mul_b[k] = loc_ff[k][cmd.j];
            end
         end
         OP_FMUL: begin
            for (int k = 0; k < 4; k++) begin
               mul_a[k] = g_ff[cmd.i][k];
               mul_b[k] = off_ff[k][cmd.j];
            end
         end
         default: begin
         end
      endcase
   end

   assign acc_sum = sext68(mul_ff[0]) + sext68(mul_ff[1]) + sext68(mul_ff[2])
                    + sext68(mul_ff[3]);

   assign req_bone_ok   = ({3'b0, req_bone_index} < 9'(MAX_BONES));
   assign take_off_addr = {2'b0, req_bone_index, 2'b0} + {8'b0, req_row_index};
   assign rd_off_addr   = {2'b0, bone_ff, 2'b0} + {8'b0, cmd.i};
   assign par_glb_addr  = 10'({4'b0, parent_ff[5:0]} * 10'd3) + {8'b0, cmd.i};
   assign wr_glb_addr   = 10'({4'b0, bone_ff} * 10'd3) + {8'b0, cmd.i};
   assign load_row      = {req_val3, req_val2, req_val1, req_val0};

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         clr_row[32*k +: 32] = (2'(k) == clr_ff[1:0]) ? ONE_Q16 : '0;
      end
   end

   // offset memory: written by the clearing pass and by row loads
   always_ff @(posedge clock) begin
      if (cmd.op == OP_CLR) begin
         off_mem[clr_ff] <= clr_row;
      end else if (cmd.op == OP_TAKE && req_command == CMD_LOAD && req_bone_ok) begin
         off_mem[OFF_AW'(take_off_addr)] <= load_row;
      end
      if (cmd.op == OP_ORD) begin
         ord_ff <= off_mem[OFF_AW'(rd_off_addr)];
      end
   end

   // global memory: one affine row per address
   always_ff @(posedge clock) begin
      if (cmd.op == OP_WR) begin
         glb_mem[GLB_AW'(wr_glb_addr)] <= {g_ff[cmd.i][3], g_ff[cmd.i][2],
                                           g_ff[cmd.i][1], g_ff[cmd.i][0]};
      end
      if (cmd.op == OP_PRD) begin
         prow_ff <= glb_mem[GLB_AW'(par_glb_addr)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.op == OP_CLR) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         mul_ff[k] <= mul_a[k] * mul_b[k];
      end
      case (cmd.op)
         OP_TAKE: begin
            bone_ff   <= req_bone_index;
            parent_ff <= req_parent_index;
            tr_ff[0]  <= req_val0;
            tr_ff[1]  <= req_val1;
            tr_ff[2]  <= req_val2;
            quat_ff   <= req_quat_packed;
            scale_ff  <= req_scale_packed;
         end
         OP_QACC: begin
            case (cmd.j)
               2'd0: for (int k = 0; k < 4; k++) qp_ff[k] <= mul_ff[k][31:0];
               2'd1: for (int k = 0; k < 4; k++) qp_ff[4+k] <= mul_ff[k][31:0];
               default: qp_ff[8] <= mul_ff[0][31:0];
            endcase
         end
         OP_SACC: begin
            for (int k = 0; k < 3; k++) begin
               loc_ff[cmd.i][k] <= sat32((sext68(mul_ff[k]) + 68'sd128) >>> 8);
            end
            loc_ff[cmd.i][3] <= tr_ff[cmd.i];
         end
         OP_ROOT: begin
            for (int r = 0; r < 3; r++) begin
               for (int c = 0; c < 4; c++) begin
                  g_ff[r][c] <= loc_ff[r][c];
               end
            end
         end
         OP_GACC: begin
            // translation column carries the parent's own translation
            if (cmd.j == 2'd3) begin
               g_ff[cmd.i][cmd.j] <= sat32((acc_sum
                  + (sext68(64'(signed'(prow_ff[127:96]))) <<< 16) + 68'sd32768) >>> 16);
            end else begin
               g_ff[cmd.i][cmd.j] <= sat32((acc_sum + 68'sd32768) >>> 16);
            end
         end
         OP_OLD: begin
            for (int c = 0; c < 4; c++) begin
               off_ff[cmd.i][c] <= ord_ff[32*c +: 32];
            end
         end
         OP_FACC: begin
            fin_ff[cmd.j] <= sat32((acc_sum + 68'sd32768) >>> 16);
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == OP_EMIT) begin
         rsp_bone_ff <= bone_ff;
         rsp_row_ff  <= cmd.i;
         rsp_last_ff <= (cmd.i == 2'd3);
         for (int c = 0; c < 4; c++) begin
            rsp_col_ff[c] <= (cmd.i == 2'd3) ? off_ff[3][c] : fin_ff[c];
         end
      end
   end

   assign status.clr_last = (clr_ff == OFF_AW'(OFF_DEPTH - 1));
   assign status.req_pose = (req_command == CMD_POSE) && req_bone_ok;
   assign status.is_root  = parent_ff[6] || ({3'b0, parent_ff[5:0]} >= 9'(MAX_BONES));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_bone = rsp_bone_ff;
   assign rsp_out_row  = rsp_row_ff;
   assign rsp_col0     = rsp_col_ff[0];
   assign rsp_col1     = rsp_col_ff[1];
   assign rsp_col2     = rsp_col_ff[2];
   assign rsp_col3     = rsp_col_ff[3];
   assign rsp_last_row = rsp_last_ff;

endmodule

/* design/bmp_controller.sv */
// controller: sequences the clearing pass and the per-bone matrix steps
`timescale 1ns / 1ps
module bmp_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bmp_pkg::status_type status,
   output bmp_pkg::cmd_type    cmd
);
   import bmp_pkg::*;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_QMUL  = 4'd2;
   localparam logic [3:0] ST_QACC  = 4'd3;
   localparam logic [3:0] ST_SMUL  = 4'd4;
   localparam logic [3:0] ST_SACC  = 4'd5;
   localparam logic [3:0] ST_ROOT  = 4'd6;
   localparam logic [3:0] ST_PRD   = 4'd7;
   localparam logic [3:0] ST_GMUL  = 4'd8;
   localparam logic [3:0] ST_GACC  = 4'd9;
   localparam logic [3:0] ST_WR    = 4'd10;
   localparam logic [3:0] ST_ORD   = 4'd11;
   localparam logic [3:0] ST_OLD   = 4'd12;
   localparam logic [3:0] ST_FMUL  = 4'd13;
   localparam logic [3:0] ST_FACC  = 4'd14;
   localparam logic [3:0] ST_EMIT  = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [1:0] i_ff, i_in;
   logic [1:0] j_ff, j_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      cmd.op   = OP_NOP;
      cmd.i    = i_ff;
      cmd.j    = j_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLR;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_TAKE;
               if (status.req_pose) begin
                  state_in = ST_QMUL;
                  i_in     = '0;
                  j_in     = '0;
               end
            end
         end
         ST_QMUL: begin
            cmd.op   = OP_QMUL;
            state_in = ST_QACC;
         end
         ST_QACC: begin
            cmd.op = OP_QACC;
            if (j_ff == 2'd2) begin
               state_in = ST_SMUL;
               j_in     = '0;
            end else begin
               state_in = ST_QMUL;
               j_in     = j_ff + 2'd1;
            end
         end
         ST_SMUL: begin
            cmd.op   = OP_SMUL;
            state_in = ST_SACC;
         end
         ST_SACC: begin
            cmd.op = OP_SACC;
            if (i_ff == 2'd2) begin
               i_in     = '0;
               state_in = status.is_root ? ST_ROOT : ST_PRD;
            end else begin
               i_in     = i_ff + 2'd1;
               state_in = ST_SMUL;
            end
         end
         ST_ROOT: begin
            cmd.op   = OP_ROOT;
            state_in = ST_WR;
         end
         ST_PRD: begin
            cmd.op   = OP_PRD;
            state_in = ST_GMUL;
            j_in     = '0;
         end
         ST_GMUL: begin
            cmd.op   = OP_GMUL;
            state_in = ST_GACC;
         end
         ST_GACC: begin
            cmd.op = OP_GACC;
            if (j_ff == 2'd3) begin
               j_in = '0;
               if (i_ff == 2'd2) begin
                  i_in     = '0;
                  state_in = ST_WR;
               end else begin
                  i_in     = i_ff + 2'd1;
                  state_in = ST_PRD;
               end
            end else begin
               j_in     = j_ff + 2'd1;
               state_in = ST_GMUL;
            end
         end
         ST_WR: begin
            cmd.op = OP_WR;
            if (i_ff == 2'd2) begin
               i_in     = '0;
               state_in = ST_ORD;
            end else begin
               i_in = i_ff + 2'd1;
            end
         end
         ST_ORD: begin
            cmd.op   = OP_ORD;
            state_in = ST_OLD;
         end
         ST_OLD: begin
            cmd.op = OP_OLD;
            if (i_ff == 2'd3) begin
               i_in     = '0;
               j_in     = '0;
               state_in = ST_FMUL;
            end else begin
               i_in     = i_ff + 2'd1;
               state_in = ST_ORD;
            end
         end
         ST_FMUL: begin
            cmd.op   = OP_FMUL;
            state_in = ST_FACC;
         end
         ST_FACC: begin
            cmd.op = OP_FACC;
            if (j_ff == 2'd3) begin
               state_in = ST_EMIT;
            end else begin
               j_in     = j_ff + 2'd1;
               state_in = ST_FMUL;
            end
         end
         ST_EMIT: begin
            // bottom row goes straight from the offset matrix
            if (status.out_free) begin
               cmd.op = OP_EMIT;
               if (i_ff == 2'd3) begin
                  i_in     = '0;
                  state_in = ST_IDLE;
               end else if (i_ff == 2'd2) begin
                  i_in = 2'd3;
               end else begin
                  i_in     = i_ff + 2'd1;
                  j_in     = '0;
                  state_in = ST_FMUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/bone_matrix_palette_unit.sv */
// Bone matrix palette unit, top level.
// A pose word takes longer for a child bone than for a root bone, plus stalls on the
// result side; the four multiplier lanes and one memory row per cycle set its length.
// A load word is written to the offset memory as it is taken. One word is in work at a time.
// After reset a clearing pass sets every offset matrix to identity; no word is accepted until
// it ends. Global matrices read undefined until written.
`timescale 1ns / 1ps
module bone_matrix_palette_unit #(
   parameter int MAX_BONES = bmp_pkg::DEFAULT_MAX_BONES
) (
   input logic      clock,
   input logic      reset,
   bmp_req_if.sink  req_chan,
   bmp_rsp_if.source rsp_chan
);
   import bmp_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       ctl_ready;

   assign req_chan.ready = ctl_ready;

   bmp_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bmp_datapath #(
      .MAX_BONES (MAX_BONES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_command      (req_chan.command),
      .req_bone_index   (req_chan.bone_index),
      .req_parent_index (req_chan.parent_index),
      .req_row_index    (req_chan.row_index),
      .req_val0         (req_chan.val0),
      .req_val1         (req_chan.val1),
      .req_val2         (req_chan.val2),
      .req_val3         (req_chan.val3),
      .req_quat_packed  (req_chan.quat_packed),
      .req_scale_packed (req_chan.scale_packed),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_out_bone     (rsp_chan.out_bone),
      .rsp_out_row      (rsp_chan.out_row),
      .rsp_col0         (rsp_chan.col0),
      .rsp_col1         (rsp_chan.col1),
      .rsp_col2         (rsp_chan.col2),
      .rsp_col3         (rsp_chan.col3),
      .rsp_last_row     (rsp_chan.last_row)
   );

endmodule
